### src/itoa_pkg.sv
// Package for the integer to ASCII radix converter.
// Holds field widths, character codes, radix limits and the digit encoder.
// No dependencies.
package itoa_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 6;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

    // Map a digit value 0..35 to '0'-'9' or 'A'-'Z'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > DIGIT_MAX_DEC) begin
            c = CHAR_A + {1'b0, d - DIGIT_TEN};
        end else begin
            c = CHAR_ZERO + {1'b0, d};
        end
        return c;
    endfunction

endpackage

### src/itoa_in_if.sv
// Input channel of the integer to ASCII converter: value and radix.
// Depends on itoa_pkg for the radix width.
interface itoa_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                              valid;
    logic                              ready;
    logic signed [VALUE_WIDTH-1:0]     value;
    logic [itoa_pkg::RADIX_W-1:0]      radix;

    modport source (output valid, value, radix, input ready);
    modport sink   (input valid, value, radix, output ready);
endinterface

### src/itoa_out_if.sv
// Output channel of the integer to ASCII converter: one character per word.
// Depends on itoa_pkg for the character width.
interface itoa_out_if;
    logic                          valid;
    logic                          ready;
    logic [itoa_pkg::CHAR_W-1:0]   character;
    logic                          last;

    modport source (output valid, character, last, input ready);
    modport sink   (input valid, character, last, output ready);
endinterface

### src/integer_to_ascii_radix.sv
// Integer to ASCII radix converter: takes a two's complement value and a radix
// (saturated to 2..36) and returns its digits as ASCII, most significant first,
// one character per output word, with last set on the final character. Zero gives
// a single '0'; in radix 10 a negative value is written as '-' and its magnitude,
// elsewhere the bits are read as unsigned. One value is converted at a time and the
// input is not ready until its final character has been taken. A single restoring
// divide step (one compare and subtract of a 7-bit partial remainder against the
// radix) is reused for every quotient bit, so each digit takes a full VALUE_WIDTH-bit
// division; digits land in a small stack memory and are read back in reverse, each
// character by a registered read and then presentation, held while output stalls.
// Depends on itoa_pkg, itoa_in_if and itoa_out_if.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itoa_in_if.sink      i_in,
    itoa_out_if.source   o_out
);

    localparam int AW    = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam logic [AW-1:0] LAST_BIT = AW'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_FETCH,
        S_SHOW
    } t_state;

    t_state                          r_state, n_state;
    logic [VALUE_WIDTH-1:0]          r_quo, n_quo;
    logic [itoa_pkg::DIGIT_W-1:0]    r_rem, n_rem;
    logic [itoa_pkg::RADIX_W-1:0]    r_radix, n_radix;
    logic                            r_neg, n_neg;
    logic [AW-1:0]                   r_bit, n_bit;
    logic [CNT_W-1:0]                r_cnt, n_cnt;
    logic [AW-1:0]                   r_ptr, n_ptr;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_last, n_out_last;

    // Digit stack, written bottom up, read top down.
    logic [itoa_pkg::CHAR_W-1:0]     r_mem [VALUE_WIDTH];
    logic [itoa_pkg::CHAR_W-1:0]     r_rd_data;
    logic                            wr_en;
    logic [itoa_pkg::CHAR_W-1:0]     wr_data;
    logic                            rd_en;

    // Shared divide step.
    logic [itoa_pkg::DIGIT_W:0]      step_t;
    logic                            step_ge;
    logic [itoa_pkg::DIGIT_W:0]      step_diff;
    logic [itoa_pkg::DIGIT_W-1:0]    step_rem;
    logic [VALUE_WIDTH-1:0]          step_quo;

    // Input decode.
    logic [itoa_pkg::RADIX_W-1:0]    in_radix;
    logic [VALUE_WIDTH-1:0]          in_bits;
    logic                            in_neg;

    assign step_t    = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign step_ge   = step_t >= {1'b0, r_radix};
    assign step_diff = step_t - {1'b0, r_radix};
    assign step_rem  = step_ge ? step_diff[itoa_pkg::DIGIT_W-1:0]
                               : step_t[itoa_pkg::DIGIT_W-1:0];
    assign step_quo  = {r_quo[VALUE_WIDTH-2:0], step_ge};

    always_comb begin
        if (i_in.radix < itoa_pkg::RADIX_MIN) begin
            in_radix = itoa_pkg::RADIX_MIN;
        end else if (i_in.radix > itoa_pkg::RADIX_MAX) begin
            in_radix = itoa_pkg::RADIX_MAX;
        end else begin
            in_radix = i_in.radix;
        end
    end

    assign in_bits = i_in.value;
    assign in_neg  = (in_radix == itoa_pkg::RADIX_DEC) && in_bits[VALUE_WIDTH-1];

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_rd_data;
    assign o_out.last      = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_radix     = r_radix;
        n_neg       = r_neg;
        n_bit       = r_bit;
        n_cnt       = r_cnt;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_data     = itoa_pkg::digit_char(step_rem);
        rd_en       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    // Take the magnitude up front; the most negative value maps onto itself.
                    n_quo   = in_neg ? (~in_bits + VALUE_WIDTH'(1)) : in_bits;
                    n_rem   = '0;
                    n_radix = in_radix;
                    n_neg   = in_neg;
                    n_bit   = LAST_BIT;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_quo = step_quo;
                n_rem = step_rem;
                n_bit = r_bit - AW'(1);
                if (r_bit == '0) begin
                    // Digit done: push it and restart on the quotient unless it ran out.
                    wr_en = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                    n_rem = '0;
                    n_bit = LAST_BIT;
                    if (step_quo == '0) begin
                        n_ptr   = r_cnt[AW-1:0];
                        n_state = r_neg ? S_SIGN : S_FETCH;
                    end
                end
            end
            S_SIGN: begin
                wr_en   = 1'b1;
                wr_data = itoa_pkg::CHAR_MINUS;
                n_ptr   = r_cnt[AW-1:0];
                n_state = S_FETCH;
            end
            S_FETCH: begin
                rd_en       = 1'b1;
                n_out_valid = 1'b1;
                n_out_last  = (r_ptr == '0);
                n_state     = S_SHOW;
            end
            S_SHOW: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr - AW'(1);
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_bit       <= '0;
            r_neg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_bit       <= n_bit;
            r_neg       <= n_neg;
        end
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_radix <= n_radix;
    end

    // Stack memory: one write port at the fill count, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cnt[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

endmodule

### test/testbench.sv
// Self-checking testbench for integer_to_ascii_radix.
// Streams signed values and radices into the converter and checks each character word against
// a local digit predictor. Depends on itoa_pkg, itoa_in_if and itoa_out_if.
`timescale 1ns / 1ps

module testbench;

    localparam int VALUE_W       = 32;
    localparam int RADIX_W       = itoa_pkg::RADIX_W;
    localparam int CHAR_W        = itoa_pkg::CHAR_W;
    localparam int RESET_CYCLES  = 11;
    // Keep the last stretch of the run free of gaps and stalls.
    localparam int CALM_TAIL     = 40;
    // Allow for anything the converter might still emit after the final word.
    localparam int SETTLE_CYCLES = 64;
    // Overall time limit for the run, with room for full output stalls.
    localparam longint TIMEOUT_NS = 64'd25_000_000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        bit                 drain;
    } t_conversion_job;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_char_word;

    logic i_clk;
    logic i_rst_n;

    itoa_in_if #(.VALUE_WIDTH(VALUE_W)) value_in ();
    itoa_out_if                         char_out ();

    integer_to_ascii_radix #(
        .VALUE_WIDTH(VALUE_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (value_in),
        .o_out   (char_out)
    );

    // Jobs waiting to be offered, filled once at time zero.
    t_conversion_job job_queue[$];
    // Characters the converter still owes, oldest first.
    t_char_word      expected_chars[$];

    t_conversion_job next_job;
    t_char_word      want_word;
    int              job_total;
    int              jobs_taken;
    int              mismatch_count;
    int              send_gap;
    bit              send_noisy;
    int              stall_left;
    bit              stall_noisy;
    logic            chars_drained;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Work out the characters for one value and append them to the expectation store.
    // Radix 10 writes a negative value as sign plus magnitude; other radices read raw bits.
    task automatic predict_conversion(input logic [VALUE_W-1:0] value,
                                      input logic [RADIX_W-1:0] radix_in);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] digit;
        logic [CHAR_W-1:0]  digits [0:VALUE_W];
        int                 count;
        bit                 negative;
        t_char_word         word;
        count    = 0;
        negative = 1'b0;
        mag      = value;
        base     = VALUE_W'(radix_in);
        // Saturate the radix into the legal range.
        if (radix_in < itoa_pkg::RADIX_MIN) begin
            base = VALUE_W'(itoa_pkg::RADIX_MIN);
        end else if (radix_in > itoa_pkg::RADIX_MAX) begin
            base = VALUE_W'(itoa_pkg::RADIX_MAX);
        end
        if (mag == '0) begin
            digits[0] = itoa_pkg::CHAR_ZERO;
            count     = 1;
        end else begin
            if (base == VALUE_W'(itoa_pkg::RADIX_DEC) && mag[VALUE_W-1]) begin
                negative = 1'b1;
                mag      = -mag;
            end
            // Peel digits least significant first.
            while (mag != '0) begin
                digit = mag % base;
                if (digit < VALUE_W'(itoa_pkg::DIGIT_TEN)) begin
                    digits[count] = CHAR_W'(itoa_pkg::CHAR_ZERO + digit);
                end else begin
                    digits[count] = CHAR_W'(itoa_pkg::CHAR_A + digit
                                            - VALUE_W'(itoa_pkg::DIGIT_TEN));
                end
                mag   = mag / base;
                count = count + 1;
            end
            if (negative) begin
                digits[count] = itoa_pkg::CHAR_MINUS;
                count         = count + 1;
            end
        end
        // Emit most significant first, flag the final character.
        for (int k = count - 1; k >= 0; k--) begin
            word.character = digits[k];
            word.last      = (k == 0);
            expected_chars.push_back(word);
        end
    endtask

    task automatic add_job(input logic [VALUE_W-1:0] value, input logic [RADIX_W-1:0] radix,
                           input bit drain);
        t_conversion_job job;
        job.value = value;
        job.radix = radix;
        job.drain = drain;
        job_queue.push_back(job);
    endtask

    // Driver: offer the next job whenever the input word is free. A job marked
    // for draining waits until every owed character has come back.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            value_in.valid <= 1'b0;
            value_in.value <= '0;
            value_in.radix <= '0;
            send_gap       <= 0;
        end else if (!value_in.valid || value_in.ready) begin
            if (send_gap > 0) begin
                send_gap       <= send_gap - 1;
                value_in.valid <= 1'b0;
            end else if (job_queue.size() != 0 && job_queue[0].drain &&
                         (value_in.valid || !chars_drained)) begin
                // Hold until the converter has emptied out.
                value_in.valid <= 1'b0;
            end else if (job_queue.size() != 0) begin
                next_job = job_queue.pop_front();
                value_in.valid <= 1'b1;
                value_in.value <= next_job.value;
                value_in.radix <= next_job.radix;
                if ($urandom_range(0, 24) == 0) begin
                    send_noisy = !send_noisy;
                end
                // Insert an idle burst after this job in noisy stretches only.
                if (send_noisy && job_queue.size() > CALM_TAIL && $urandom_range(0, 2) == 0) begin
                    send_gap <= $urandom_range(1, 7);
                end else begin
                    send_gap <= 0;
                end
            end else begin
                value_in.valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted input word, then check each accepted
    // character word against the oldest expectation. Also drive output stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_out.ready <= 1'b0;
            stall_left     <= 0;
            chars_drained  <= 1'b1;
        end else begin
            if (value_in.valid && value_in.ready) begin
                predict_conversion(value_in.value, value_in.radix);
                jobs_taken = jobs_taken + 1;
            end
            if (char_out.valid && char_out.ready) begin
                if (expected_chars.size() == 0) begin
                    $error("character: expected none, got %h ('%c') last=%b",
                           char_out.character, char_out.character, char_out.last);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want_word = expected_chars.pop_front();
                    if (char_out.character !== want_word.character) begin
                        $error("character: expected %h ('%c'), got %h ('%c')",
                               want_word.character, want_word.character,
                               char_out.character, char_out.character);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (char_out.last !== want_word.last) begin
                        $error("last: expected %b, got %b", want_word.last, char_out.last);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            chars_drained <= (expected_chars.size() == 0);

            if ($urandom_range(0, 39) == 0) begin
                stall_noisy = !stall_noisy;
            end
            if (stall_left > 0) begin
                stall_left     <= stall_left - 1;
                char_out.ready <= 1'b0;
            end else if (stall_noisy && jobs_taken < job_total - CALM_TAIL &&
                         $urandom_range(0, 5) == 0) begin
                // Start a stall burst: ready drops now and stays low while stall_left counts down.
                stall_left     <= $urandom_range(0, 6);
                char_out.ready <= 1'b0;
            end else begin
                char_out.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;

        i_rst_n        <= 1'b0;
        mismatch_count = 0;
        jobs_taken     = 0;
        send_noisy     = 1'b1;
        stall_noisy    = 1'b1;

        // Directed: zero, extremes, sign handling, radix saturation, digit edges.
        add_job(32'h0000_0000, 6'd10, 1'b0);
        add_job(32'h0000_0000, 6'd2,  1'b0);
        add_job(32'h0000_0000, 6'd36, 1'b0);
        add_job(32'h7FFF_FFFF, 6'd10, 1'b0);
        add_job(32'h8000_0000, 6'd10, 1'b0);  // most negative: magnitude 2147483648
        add_job(32'hFFFF_FFFF, 6'd10, 1'b0);
        add_job(-32'sd42,      6'd10, 1'b0);
        add_job(32'hFFFF_FFFF, 6'd2,  1'b0);  // longest string: 32 ones
        add_job(32'h8000_0000, 6'd2,  1'b0);
        add_job(32'hFFFF_FFFF, 6'd16, 1'b0);
        add_job(32'hFFFF_FFFF, 6'd36, 1'b0);
        add_job(32'h8000_0000, 6'd36, 1'b0);
        add_job(32'h7FFF_FFFF, 6'd36, 1'b0);
        add_job(32'd12345,     6'd0,  1'b0);  // radix below two saturates up
        add_job(32'd255,       6'd1,  1'b0);
        add_job(32'd35,        6'd37, 1'b0);  // radix above 36 saturates down
        add_job(32'd1295,      6'd63, 1'b0);
        add_job(32'd10,        6'd11, 1'b0);
        add_job(32'd35,        6'd36, 1'b0);
        add_job(32'd42,        6'd16, 1'b0);
        add_job(32'h5555_5555, 6'd4,  1'b0);
        add_job(32'd1,         6'd2,  1'b0);
        add_job(32'd123456789, 6'd8,  1'b0);
        add_job(32'd9,         6'd10, 1'b0);

        // Random jobs; every hundredth waits for the converter to drain first.
        for (int i = 0; i < 300; i++) begin
            case ($urandom_range(0, 5))
                0:       value = $urandom();
                1:       value = $urandom() >> $urandom_range(0, 31);
                2:       value = -($urandom() >> $urandom_range(1, 31));
                3:       value = $urandom_range(0, 1000);
                4: begin
                    case ($urandom_range(0, 4))
                        0:       value = 32'h8000_0000;
                        1:       value = 32'h7FFF_FFFF;
                        2:       value = 32'hFFFF_FFFF;
                        3:       value = 32'h8000_0001;
                        default: value = 32'h0000_0000;
                    endcase
                end
                default: value = $urandom();
            endcase
            case ($urandom_range(0, 9))
                0:       radix = $urandom_range(0, 63);
                1, 2:    radix = itoa_pkg::RADIX_DEC;
                3:       radix = $urandom_range(2, 4);
                default: radix = $urandom_range(2, 36);
            endcase
            add_job(value, radix, (i % 100) == 0);
        end
        job_total = job_queue.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last job to be taken, then for every owed character.
        while (job_queue.size() != 0 || value_in.valid) @(negedge i_clk);
        while (expected_chars.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### integer_to_ascii_radix.f
src/itoa_pkg.sv
src/itoa_in_if.sv
src/itoa_out_if.sv
src/integer_to_ascii_radix.sv
test/testbench.sv
